### rtl/hstr_pkg.sv
// Package for the half-space triangle rasterizer: shared constants and command codes.
`default_nettype none

package hstr_pkg;

  localparam int unsigned COORD_BITS_DEF = 10;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_e;

endpackage

`default_nettype wire

### rtl/hstr_edge.sv
// One edge function unit: the two cross products and the strict sign test.
`default_nettype none

module hstr_edge #(
  parameter int unsigned COORD_BITS = hstr_pkg::COORD_BITS_DEF
) (
  input  wire logic [COORD_BITS-1:0] px_i,
  input  wire logic [COORD_BITS-1:0] py_i,
  input  wire logic [COORD_BITS-1:0] qx_i,
  input  wire logic [COORD_BITS-1:0] qy_i,
  input  wire logic [COORD_BITS-1:0] x_i,
  input  wire logic [COORD_BITS-1:0] y_i,
  output logic                       neg_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;

  logic signed [DW-1:0] dx, dy, rx, ry;
  logic signed [PW-1:0] prod_a, prod_b;

  assign dx = $signed({1'b0, qx_i}) - $signed({1'b0, px_i});
  assign dy = $signed({1'b0, qy_i}) - $signed({1'b0, py_i});
  assign rx = $signed({1'b0, x_i}) - $signed({1'b0, px_i});
  assign ry = $signed({1'b0, y_i}) - $signed({1'b0, py_i});

  assign prod_a = PW'(dx) * PW'(ry);
  assign prod_b = PW'(dy) * PW'(rx);

  // dx*ry - dy*rx < 0
  assign neg_o = prod_a < prod_b;

endmodule

`default_nettype wire

### rtl/halfspace_triangle_rasterizer_unit.sv
// Half-space triangle rasterizer top level: scan control, edge tests and output register.
// Input channel s_axis: tuser carries the command. A load item (CMD_LOAD) brings the
// three vertices in tdata and produces no result; a step item (CMD_STEP) tests the
// next bounding box position in row-major order and produces exactly one result.
// Output channel m_axis: tdata holds pixel_x and pixel_y, tlast marks the final
// position of the box, tuser holds covered and valid_res. A step with no triangle
// in progress returns an all-zero result with valid_res 0.
// A step item's result is registered and appears on m_axis in the cycle after it is accepted;
// the edge tests run from the scan registers straight into the output register.
// Throughput: one item per cycle while m_axis takes results; the scan position advances at
// accept time with a single increment and compare.
// Reset clears the scan state and the vertex store and leaves the block idle.
// A stall on m_axis holds the output register; s_axis_tready drops only while the
// output register holds a result that is not taken.
`default_nettype none

module halfspace_triangle_rasterizer_unit #(
  parameter int unsigned COORD_BITS = hstr_pkg::COORD_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,

  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y
  input  wire logic [((6*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // cmd
  input  wire logic                                   s_axis_tuser,

  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // pixel_x, pixel_y
  output logic [((2*COORD_BITS+7)/8)*8-1:0]           m_axis_tdata,
  // last_position
  output logic                                        m_axis_tlast,
  // covered, valid_res
  output logic [1:0]                                  m_axis_tuser
);

  localparam int unsigned W = COORD_BITS;

  typedef logic [W-1:0] coord_t;

  function automatic coord_t min3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic coord_t max3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // scan state
  coord_t vtx_q [6];
  coord_t vtx_d [6];
  coord_t scan_x_q, scan_x_d, scan_y_q, scan_y_d;
  coord_t box_xl_q, box_xl_d, box_xh_q, box_xh_d, box_yh_q, box_yh_d;
  logic   busy_q, busy_d;

  // output register
  logic   o_vld_q, o_vld_d, o_last_q, o_last_d, o_res_q, o_res_d, o_cov_q, o_cov_d;
  coord_t o_x_q, o_x_d, o_y_q, o_y_d;

  logic   adv, acc, is_load;
  logic   row_end, last_pos;
  logic   neg1, neg2, neg3;
  coord_t in_vtx [6];

  assign adv           = !o_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign is_load       = hstr_pkg::cmd_e'(s_axis_tuser) == hstr_pkg::CMD_LOAD;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      in_vtx[i] = s_axis_tdata[i*W +: W];
    end
  end

  assign row_end  = scan_x_q >= box_xh_q;
  assign last_pos = row_end && (scan_y_q >= box_yh_q);

  always_comb begin
    vtx_d    = vtx_q;
    scan_x_d = scan_x_q;
    scan_y_d = scan_y_q;
    box_xl_d = box_xl_q;
    box_xh_d = box_xh_q;
    box_yh_d = box_yh_q;
    busy_d   = busy_q;
    o_vld_d  = 1'b0;
    o_last_d = 1'b0;
    o_res_d  = 1'b0;
    o_cov_d  = 1'b0;
    o_x_d    = '0;
    o_y_d    = '0;
    if (acc) begin
      if (is_load) begin
        vtx_d    = in_vtx;
        box_xl_d = min3(in_vtx[0], in_vtx[2], in_vtx[4]);
        box_xh_d = max3(in_vtx[0], in_vtx[2], in_vtx[4]);
        box_yh_d = max3(in_vtx[1], in_vtx[3], in_vtx[5]);
        scan_x_d = min3(in_vtx[0], in_vtx[2], in_vtx[4]);
        scan_y_d = min3(in_vtx[1], in_vtx[3], in_vtx[5]);
        busy_d   = 1'b1;
      end else begin
        o_vld_d = 1'b1;
        if (busy_q) begin
          o_res_d  = 1'b1;
          o_x_d    = scan_x_q;
          o_y_d    = scan_y_q;
          o_last_d = last_pos;
          o_cov_d  = neg1 && neg2 && neg3;
          if (last_pos) begin
            busy_d = 1'b0;
          end else if (row_end) begin
            scan_x_d = box_xl_q;
            scan_y_d = scan_y_q + coord_t'(1);
          end else begin
            scan_x_d = scan_x_q + coord_t'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        vtx_q[i] <= '0;
      end
      scan_x_q <= '0;
      scan_y_q <= '0;
      box_xl_q <= '0;
      box_xh_q <= '0;
      box_yh_q <= '0;
      busy_q   <= 1'b0;
      o_vld_q  <= 1'b0;
    end else begin
      vtx_q    <= vtx_d;
      scan_x_q <= scan_x_d;
      scan_y_q <= scan_y_d;
      box_xl_q <= box_xl_d;
      box_xh_q <= box_xh_d;
      box_yh_q <= box_yh_d;
      busy_q   <= busy_d;
      if (adv) begin
        o_vld_q <= o_vld_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_x_q    <= o_x_d;
      o_y_q    <= o_y_d;
      o_last_q <= o_last_d;
      o_res_q  <= o_res_d;
      o_cov_q  <= o_cov_d;
    end
  end

  // edges A->B, B->C, C->A
  hstr_edge #(.COORD_BITS(COORD_BITS)) u_edge_ab (
    .px_i  (vtx_q[0]),
    .py_i  (vtx_q[1]),
    .qx_i  (vtx_q[2]),
    .qy_i  (vtx_q[3]),
    .x_i   (scan_x_q),
    .y_i   (scan_y_q),
    .neg_o (neg1)
  );

  hstr_edge #(.COORD_BITS(COORD_BITS)) u_edge_bc (
    .px_i  (vtx_q[2]),
    .py_i  (vtx_q[3]),
    .qx_i  (vtx_q[4]),
    .qy_i  (vtx_q[5]),
    .x_i   (scan_x_q),
    .y_i   (scan_y_q),
    .neg_o (neg2)
  );

  hstr_edge #(.COORD_BITS(COORD_BITS)) u_edge_ca (
    .px_i  (vtx_q[4]),
    .py_i  (vtx_q[5]),
    .qx_i  (vtx_q[0]),
    .qy_i  (vtx_q[1]),
    .x_i   (scan_x_q),
    .y_i   (scan_y_q),
    .neg_o (neg3)
  );

  always_comb begin
    m_axis_tdata          = '0;
    m_axis_tdata[W-1:0]   = o_x_q;
    m_axis_tdata[2*W-1:W] = o_y_q;
  end

  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tuser  = {o_res_q, o_cov_q};

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |->
      m_axis_tdata == '0 && !m_axis_tlast && !m_axis_tuser[0])
    else $error("idle step result not zero");

  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && is_load |=> busy_q)
    else $error("load did not start a scan");

  a_scan_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> scan_x_q >= box_xl_q && scan_x_q <= box_xh_q && scan_y_q <= box_yh_q)
    else $error("scan position left the bounding box");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
    else $error("last position flagged on an invalid result");

endmodule

`default_nettype wire

### tb/testbench.sv
// Testbench for the half-space triangle rasterizer: directed table, random triangles, scoreboard.
`timescale 1ns / 100ps

module testbench;

  localparam int CW    = hstr_pkg::COORD_BITS_DEF;
  localparam int VW    = 6 * CW;
  localparam int IN_W  = ((6 * CW + 7) / 8) * 8;
  localparam int OUT_W = ((2 * CW + 7) / 8) * 8;
  localparam int MAX_C = (1 << CW) - 1;
  localparam int N_RANDOM = 700;

  typedef struct packed {
    hstr_pkg::cmd_e      cmd;
    logic [5:0][CW-1:0]  vtx;  // ax, ay, bx, by, cx, cy from index 0 up
  } tri_item_t;

  typedef struct packed {
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic          cov;
    logic          last;
    logic          ok;
  } pix_res_t;

  typedef struct packed {
    tri_item_t it;
    logic      typed;
    pix_res_t  res;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;
  logic [1:0]       m_axis_tuser;

  // predictor state
  logic [5:0][CW-1:0] tri_vtx;
  logic [CW-1:0]      scan_px, scan_py, box_xlo, box_xhi, box_yhi;
  logic               scan_busy;

  pix_res_t  pixel_q[$];
  pix_res_t  got, want;
  dir_row_t  dir_rows[$];
  int        n_errors = 0;
  int        src_idle_pct = 15;
  int        dst_idle_pct = 62;

  halfspace_triangle_rasterizer_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [CW-1:0] min3(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c);
    logic [CW-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic [CW-1:0] max3(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c);
    logic [CW-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic longint edge_val(int px, int py, int qx, int qy, int x, int y);
    return longint'(qx - px) * longint'(y - py) - longint'(qy - py) * longint'(x - px);
  endfunction

  task automatic raster_predict(input tri_item_t it, output bit has_res, output pix_res_t r);
    longint e1, e2, e3;
    bit     row_end;
    int     ax, ay, bx, by, cx, cy, x, y;
    r = '0;
    has_res = 1'b0;
    if (it.cmd == hstr_pkg::CMD_LOAD) begin
      tri_vtx   = it.vtx;
      box_xlo   = min3(it.vtx[0], it.vtx[2], it.vtx[4]);
      box_xhi   = max3(it.vtx[0], it.vtx[2], it.vtx[4]);
      box_yhi   = max3(it.vtx[1], it.vtx[3], it.vtx[5]);
      scan_px   = box_xlo;
      scan_py   = min3(it.vtx[1], it.vtx[3], it.vtx[5]);
      scan_busy = 1'b1;
    end else begin
      has_res = 1'b1;
      if (scan_busy) begin
        ax = tri_vtx[0]; ay = tri_vtx[1];
        bx = tri_vtx[2]; by = tri_vtx[3];
        cx = tri_vtx[4]; cy = tri_vtx[5];
        x = scan_px; y = scan_py;
        e1 = edge_val(ax, ay, bx, by, x, y);
        e2 = edge_val(bx, by, cx, cy, x, y);
        e3 = edge_val(cx, cy, ax, ay, x, y);
        row_end = (scan_px >= box_xhi);
        r.px   = scan_px;
        r.py   = scan_py;
        r.cov  = (e1 < 0) && (e2 < 0) && (e3 < 0);
        r.last = row_end && (scan_py >= box_yhi);
        r.ok   = 1'b1;
        if (r.last) begin
          scan_busy = 1'b0;
        end else if (row_end) begin
          scan_px = box_xlo;
          scan_py = scan_py + 1'b1;
        end else begin
          scan_px = scan_px + 1'b1;
        end
      end
    end
  endtask

  task automatic send_item(input tri_item_t it, input bit typed, input pix_res_t typed_res);
    bit       has_res;
    pix_res_t r;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(it.vtx);
    s_axis_tuser  <= it.cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    raster_predict(it, has_res, r);
    if (has_res) pixel_q = {pixel_q, (typed ? typed_res : r)};
  endtask

  task automatic add_row(input hstr_pkg::cmd_e cmd, input int ax, input int ay, input int bx,
                         input int by, input int cx, input int cy, input bit typed,
                         input int px, input int py, input bit cov, input bit last,
                         input bit ok);
    dir_row_t d;
    d.it.cmd    = cmd;
    d.it.vtx[0] = CW'(ax); d.it.vtx[1] = CW'(ay);
    d.it.vtx[2] = CW'(bx); d.it.vtx[3] = CW'(by);
    d.it.vtx[4] = CW'(cx); d.it.vtx[5] = CW'(cy);
    d.typed     = typed;
    d.res.px    = CW'(px);
    d.res.py    = CW'(py);
    d.res.cov   = cov;
    d.res.last  = last;
    d.res.ok    = ok;
    dir_rows = {dir_rows, d};
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.px   = m_axis_tdata[CW-1:0];
      got.py   = m_axis_tdata[2*CW-1:CW];
      got.cov  = m_axis_tuser[0];
      got.ok   = m_axis_tuser[1];
      got.last = m_axis_tlast;
      if (pixel_q.size() == 0) begin
        $error("unexpected result px=%0d py=%0d", got.px, got.py);
        n_errors++;
      end else begin
        want = pixel_q.pop_front();
        if (got.px !== want.px) begin
          $error("pixel_x expected %0d actual %0d", want.px, got.px);
          n_errors++;
        end
        if (got.py !== want.py) begin
          $error("pixel_y expected %0d actual %0d", want.py, got.py);
          n_errors++;
        end
        if (got.cov !== want.cov) begin
          $error("covered expected %0b actual %0b", want.cov, got.cov);
          n_errors++;
        end
        if (got.last !== want.last) begin
          $error("last_position expected %0b actual %0b", want.last, got.last);
          n_errors++;
        end
        if (got.ok !== want.ok) begin
          $error("valid_res expected %0b actual %0b", want.ok, got.ok);
          n_errors++;
        end
      end
    end
  end

  initial begin
    tri_item_t it;
    int        n_items, kind, sw, sh, ox, oy, steps, area, r;
    tri_vtx   = '0;
    scan_px   = '0;
    scan_py   = '0;
    box_xlo   = '0;
    box_xhi   = '0;
    box_yhi   = '0;
    scan_busy = 1'b0;

    // step while idle, single-pixel boxes at both extremes
    add_row(hstr_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_row(hstr_pkg::CMD_LOAD, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, 0, 0, 0, 0, 0, 0);
    add_row(hstr_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0, 1, MAX_C, MAX_C, 0, 1, 1);
    add_row(hstr_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_row(hstr_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(hstr_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 1);
    // full-screen triangle, dropped mid-scan by a new load
    add_row(hstr_pkg::CMD_LOAD, 0, 0, 0, MAX_C, MAX_C, 0, 0, 0, 0, 0, 0, 0);
    repeat (2) add_row(hstr_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // 3x3 box in the far corner with one covered pixel, then idle step
    add_row(hstr_pkg::CMD_LOAD, MAX_C - 2, MAX_C - 2, MAX_C - 2, MAX_C, MAX_C, MAX_C - 1,
            0, 0, 0, 0, 0, 0);
    repeat (9) add_row(hstr_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(hstr_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);

    n_items = 0;
    while (n_items < N_RANDOM) begin
      if (n_items < N_RANDOM / 3) begin
        src_idle_pct = 15; dst_idle_pct = 62;
      end else if (n_items < 2 * N_RANDOM / 3) begin
        src_idle_pct = 62; dst_idle_pct = 15;
      end else begin
        src_idle_pct = 0; dst_idle_pct = 0;
      end
      it.cmd = hstr_pkg::CMD_LOAD;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        it.vtx = VW'({$urandom(), $urandom()});
      end else begin
        sw = $urandom_range(0, 5);
        sh = $urandom_range(0, 5);
        r  = $urandom_range(0, 4);
        ox = (r == 0) ? 0 : (r == 1) ? MAX_C - sw : $urandom_range(0, MAX_C - sw);
        r  = $urandom_range(0, 4);
        oy = (r == 0) ? 0 : (r == 1) ? MAX_C - sh : $urandom_range(0, MAX_C - sh);
        for (int k = 0; k < 3; k++) begin
          it.vtx[2*k]   = CW'(ox + $urandom_range(0, sw));
          it.vtx[2*k+1] = CW'(oy + $urandom_range(0, sh));
        end
      end
      send_item(it, 1'b0, '0);
      n_items++;
      if (kind == 0) begin
        steps = $urandom_range(0, 4);
      end else begin
        area = (int'(box_xhi) - int'(box_xlo) + 1) * (int'(box_yhi) - int'(scan_py) + 1);
        r = $urandom_range(0, 9);
        steps = (r == 0) ? $urandom_range(0, area) :
                (r == 1) ? area + $urandom_range(1, 3) : area;
      end
      repeat (steps) begin
        it.cmd = hstr_pkg::CMD_STEP;
        it.vtx = VW'({$urandom(), $urandom()});
        send_item(it, 1'b0, '0);
        n_items++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
